// File: design/tx_timestamp_request_id_tracker_core_defines.svh
// Assertion macros used by the tracker datapath (tx_tsid_dp).
`ifndef TX_TIMESTAMP_REQUEST_ID_TRACKER_CORE_DEFINES_SVH
`define TX_TIMESTAMP_REQUEST_ID_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TSID_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tracker check failed");

// Next-cycle implication, disabled while reset is low.
`define TSID_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tracker sequence check failed");

`endif

// File: design/tx_tsid_pkg.sv
`default_nettype none

package tx_tsid_pkg;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_SWEEP  = 2'd2;

    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_NOFREE  = 3'd1;
    localparam logic [2:0] ST_MATCHED = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_EXPIRED = 3'd4;

    // Register map: one 32-bit register, selected by paddr[2].
    localparam int         ADDR_W      = 3;
    localparam logic       REG_EXPIRY  = 1'b0;
    localparam int         EXPIRY_W    = 31;
    localparam logic [30:0] EXPIRY_RESET = 31'd5000;

    // Most IDs released by one sweep.
    localparam int MAX_SWEEP = 16;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic accept;   // latch the input word, restart the scan
        logic exec;     // resolve allocate or report into the output
        logic take;     // release the scanned ID, push any held expiry
        logic next;     // advance the scan index
        logic flush;    // push the held expiry as the final word
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic hit;
        logic pend_valid;
        logic scan_end;
        logic cnt_full;
    } t_stat;

endpackage

`default_nettype wire

// File: design/tx_tsid_if.sv
`default_nettype none

interface tx_tsid_in_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [3:0]            req_id;
    logic [63:0]           hw_timestamp;
    logic [TIME_WIDTH-1:0] now_ticks;

    modport source (output valid, func, req_id, hw_timestamp, now_ticks, input ready);
    modport sink   (input valid, func, req_id, hw_timestamp, now_ticks, output ready);
endinterface

interface tx_tsid_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot_id;
    logic [63:0] out_timestamp;
    logic        last_result;

    modport source (output valid, status, slot_id, out_timestamp, last_result, input ready);
    modport sink   (input valid, status, slot_id, out_timestamp, last_result, output ready);
endinterface

`default_nettype wire

// File: design/tx_tsid_cfg.sv
`default_nettype none

module tx_tsid_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tx_tsid_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output logic      [tx_tsid_pkg::EXPIRY_W-1:0] o_expiry
);

    logic [tx_tsid_pkg::EXPIRY_W-1:0] r_expiry;
    logic                             wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == tx_tsid_pkg::REG_EXPIRY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= tx_tsid_pkg::EXPIRY_RESET;
        end else if (wr_en) begin
            r_expiry <= pwdata[tx_tsid_pkg::EXPIRY_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == tx_tsid_pkg::REG_EXPIRY) begin
            prdata = {1'b0, r_expiry};
        end else begin
            prdata = 32'd0;
        end
    end

    assign pready   = 1'b1;
    assign o_expiry = r_expiry;

endmodule

`default_nettype wire

// File: design/tx_tsid_ctrl.sv
`default_nettype none

module tx_tsid_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_in_func,
    input  wire tx_tsid_pkg::t_stat i_stat,
    output logic                    o_in_ready,
    output tx_tsid_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SW_RD,
        S_SW_CHK,
        S_SW_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_func)
                        tx_tsid_pkg::FUNC_ALLOC:  n_state = S_EXEC;
                        tx_tsid_pkg::FUNC_REPORT: n_state = S_EXEC;
                        tx_tsid_pkg::FUNC_SWEEP:  n_state = S_SW_RD;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SW_RD: begin
                n_state = S_SW_CHK;
            end
            S_SW_CHK: begin
                if (i_stat.hit) begin
                    // a held expiry must leave before the new one replaces it
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.take = 1'b1;
                        if (i_stat.cnt_full || i_stat.scan_end) begin
                            n_state = S_SW_FLUSH;
                        end else begin
                            o_cmd.next = 1'b1;
                            n_state    = S_SW_RD;
                        end
                    end
                end else if (i_stat.scan_end) begin
                    n_state = S_SW_FLUSH;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_SW_RD;
                end
            end
            S_SW_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/tx_tsid_dp.sv
`default_nettype none
`include "tx_timestamp_request_id_tracker_core_defines.svh"

module tx_tsid_dp #(
    parameter int NUM_IDS    = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tx_tsid_pkg::t_cmd                i_cmd,
    output tx_tsid_pkg::t_stat                    o_stat,
    input  wire logic [1:0]                       i_func,
    input  wire logic [3:0]                       i_req_id,
    input  wire logic [63:0]                      i_hw_timestamp,
    input  wire logic [TIME_WIDTH-1:0]            i_now_ticks,
    input  wire logic [tx_tsid_pkg::EXPIRY_W-1:0] i_expiry,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [2:0]                            o_status,
    output logic [3:0]                            o_slot_id,
    output logic [63:0]                           o_out_timestamp,
    output logic                                  o_last_result
);

    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CW    = tx_tsid_pkg::CNT_W;

    logic [NUM_IDS-1:0]    r_busy;
    logic [TIME_WIDTH-1:0] r_start_mem [NUM_IDS];
    logic [TIME_WIDTH-1:0] r_rdata;

    logic [1:0]            r_func;
    logic [3:0]            r_rid;
    logic [63:0]           r_ts;
    logic [TIME_WIDTH-1:0] r_now;

    logic [IDX_W-1:0]      r_scan;
    logic [CW-1:0]         r_cnt;
    logic                  r_pend_valid;
    logic [IDX_W-1:0]      r_pend_id;

    logic                  r_out_valid;
    logic [2:0]            r_out_status;
    logic [3:0]            r_out_slot;
    logic [63:0]           r_out_ts;
    logic                  r_out_last;

    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [7:0]            free_wide;
    logic [7:0]            rid_wide;
    logic [IDX_W-1:0]      rid_idx;
    logic                  matched;
    logic [7:0]            pend_wide;
    logic [63:0]           exp_wide;
    logic [TIME_WIDTH-1:0] exp_t;
    logic [TIME_WIDTH-1:0] age_diff;
    logic                  hit;
    logic                  grant;
    logic                  out_free;
    logic                  out_load;

    // lowest free ID
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign free_wide = {{(8 - IDX_W){1'b0}}, free_idx};
    assign pend_wide = {{(8 - IDX_W){1'b0}}, r_pend_id};
    assign rid_wide  = {4'd0, r_rid};
    assign rid_idx   = rid_wide[IDX_W-1:0];
    assign matched   = (rid_wide < 8'(NUM_IDS)) && r_busy[rid_idx];

    // expired when (now - start - expiry) is non-negative in wrapping time
    assign exp_wide = {{(64 - tx_tsid_pkg::EXPIRY_W){1'b0}}, i_expiry};
    assign exp_t    = exp_wide[TIME_WIDTH-1:0];
    assign age_diff = r_now - r_rdata - exp_t;
    assign hit      = r_busy[r_scan] && !age_diff[TIME_WIDTH-1];

    assign grant    = i_cmd.exec && (r_func == tx_tsid_pkg::FUNC_ALLOC) && free_found;
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.exec || (i_cmd.take && r_pend_valid) || i_cmd.flush;

    assign o_stat.out_free   = out_free;
    assign o_stat.hit        = hit;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.scan_end   = (r_scan == IDX_W'(NUM_IDS - 1));
    assign o_stat.cnt_full   = (r_cnt == CW'(tx_tsid_pkg::MAX_SWEEP - 1));

    // start-time store
    always_ff @(posedge i_clk) begin
        if (grant) begin
            r_start_mem[free_idx] <= r_now;
        end
        r_rdata <= r_start_mem[r_scan];
    end

    // latched input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_rid  <= i_req_id;
            r_ts   <= i_hw_timestamp;
            r_now  <= i_now_ticks;
        end
    end

    // busy map and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_scan       <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_id    <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_scan       <= '0;
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
            end
            if (grant) begin
                r_busy[free_idx] <= 1'b1;
            end
            if (i_cmd.exec && (r_func == tx_tsid_pkg::FUNC_REPORT) && matched) begin
                r_busy[rid_idx] <= 1'b0;
            end
            if (i_cmd.take) begin
                r_busy[r_scan] <= 1'b0;
                r_pend_valid   <= 1'b1;
                r_pend_id      <= r_scan;
                r_cnt          <= r_cnt + CW'(1);
            end
            if (i_cmd.next) begin
                r_scan <= r_scan + IDX_W'(1);
            end
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_last <= 1'b1;
            if (r_func == tx_tsid_pkg::FUNC_ALLOC) begin
                r_out_status <= free_found ? tx_tsid_pkg::ST_GRANTED : tx_tsid_pkg::ST_NOFREE;
                r_out_slot   <= free_found ? free_wide[3:0] : 4'd0;
                r_out_ts     <= 64'd0;
            end else begin
                r_out_status <= matched ? tx_tsid_pkg::ST_MATCHED : tx_tsid_pkg::ST_UNKNOWN;
                r_out_slot   <= r_rid;
                r_out_ts     <= matched ? r_ts : 64'd0;
            end
        end else if ((i_cmd.take && r_pend_valid) || i_cmd.flush) begin
            r_out_status <= tx_tsid_pkg::ST_EXPIRED;
            r_out_slot   <= pend_wide[3:0];
            r_out_ts     <= 64'd0;
            r_out_last   <= i_cmd.flush;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_id       = r_out_slot;
    assign o_out_timestamp = r_out_ts;
    assign o_last_result   = r_out_last;

    `TSID_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, out_load && r_out_valid, i_out_ready)
    `TSID_ASSERT_NEXT(a_take_frees, i_clk, i_rst_n, i_cmd.take, !r_busy[$past(r_scan)])
    `TSID_ASSERT_NOW(a_sweep_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(tx_tsid_pkg::MAX_SWEEP))
    `TSID_ASSERT_NOW(a_ts_only_matched, i_clk, i_rst_n,
        r_out_valid && (r_out_status != tx_tsid_pkg::ST_MATCHED), r_out_ts == 64'd0)

endmodule

`default_nettype wire

// File: design/tx_timestamp_request_id_tracker_core.sv
// Transmit timestamp request ID tracker.
// Input channel i_item carries one word per operation: allocate (lowest free
// ID granted and its start tick recorded), timestamp report (a busy ID is
// released and the timestamp handed on) or expiry sweep (every busy ID whose
// age has reached expiry_ticks is released, lowest first, at most sixteen).
// Output channel o_result returns one word for allocate and report, one word
// per released ID for a sweep (last_result on the final one) and none for an
// empty sweep or an unused operation code.
// Allocate and report: the controller latches the word on acceptance, then in
// S_EXEC resolves it into the output register once that register is free;
// no new word is taken until the controller is back in S_IDLE.
// Sweep: each ID scanned takes a start-time read (S_SW_RD) and an age check
// (S_SW_CHK), and a final flush (S_SW_FLUSH) ends it; no input is taken meanwhile.
// The APB port holds expiry_ticks at offset 0; pready is tied high.
// Reset clears the busy map (no ID outstanding) and loads expiry_ticks 5000.
// While the receiver stalls, the output register holds its word; a further
// input word is still taken, its result waits inside until the register
// drains, and the input is held off meanwhile.
`default_nettype none

module tx_timestamp_request_id_tracker_core #(
    parameter int NUM_IDS    = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tx_tsid_in_if.sink                          i_item,
    tx_tsid_out_if.source                       o_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tx_tsid_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    tx_tsid_pkg::t_cmd                cmd;
    tx_tsid_pkg::t_stat               stat;
    logic                             in_ready;
    logic [tx_tsid_pkg::EXPIRY_W-1:0] expiry;

    assign i_item.ready = in_ready;

    // register port
    tx_tsid_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_expiry (expiry)
    );

    // sequencing of allocate, report and sweep
    tx_tsid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_func  (i_item.func),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // busy map, start times, sweep scan and output register
    tx_tsid_dp #(
        .NUM_IDS    (NUM_IDS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_item.func),
        .i_req_id        (i_item.req_id),
        .i_hw_timestamp  (i_item.hw_timestamp),
        .i_now_ticks     (i_item.now_ticks),
        .i_expiry        (expiry),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_status        (o_result.status),
        .o_slot_id       (o_result.slot_id),
        .o_out_timestamp (o_result.out_timestamp),
        .o_last_result   (o_result.last_result)
    );

endmodule

`default_nettype wire

// File: verif/tx_timestamp_request_id_tracker_core_tb.sv
`default_nettype none

module tx_timestamp_request_id_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_IDS    = 16;
    localparam int TIME_WIDTH = 32;

    // Operation code that the block drops without a result.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Allow a full sweep of every ID and a margin before touching the register
    // after the last result word.
    localparam int SETTLE_CYCLES   = 2 * NUM_IDS + 24;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES      = 5;

    typedef struct packed {
        logic [1:0]            func;
        logic [3:0]            req_id;
        logic [63:0]           hw_ts;
        logic [TIME_WIDTH-1:0] now;
    } t_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_id;
        logic [63:0] ts;
        logic        last;
    } t_outcome;

    // One stimulus row: the word, and a hand-written result where it is obvious.
    typedef struct {
        t_word    w;
        bit       typed;
        t_outcome want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tx_tsid_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    tx_tsid_in_if #(.TIME_WIDTH(TIME_WIDTH)) item_if ();
    tx_tsid_out_if                           res_if ();

    tx_timestamp_request_id_tracker_core #(
        .NUM_IDS    (NUM_IDS),
        .TIME_WIDTH (TIME_WIDTH)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Tracker image: which IDs are outstanding, when each was granted, and
    // the expiry age currently programmed.
    logic [NUM_IDS-1:0]               id_busy;
    logic [TIME_WIDTH-1:0]            id_start [NUM_IDS];
    logic [tx_tsid_pkg::EXPIRY_W-1:0] expiry_age;

    t_outcome  awaited[$];
    t_stim_row dir_rows[$];

    int              errors = 0;
    int              cycles = 0;
    bit              steady = 1'b0;
    logic [31:0]     tick;
    logic [31:0]     expiry_plan [NUM_PHASES] = '{
        32'd1, 32'd0, 32'hFFFF_FFFF, 32'd300, 32'd5000
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Guard against a hang: give up long after the slowest legal run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Work out the result words one accepted input word causes, and advance
    // the tracker image to match.
    task automatic track_word(input t_word w, output t_outcome res[$]);
        int                    grant;
        int                    freed;
        logic [TIME_WIDTH-1:0] overdue;
        res   = {};
        grant = -1;
        freed = 0;
        case (w.func)
            tx_tsid_pkg::FUNC_ALLOC: begin
                // Lowest free ID wins.
                for (int i = NUM_IDS - 1; i >= 0; i--) begin
                    if (!id_busy[i]) grant = i;
                end
                if (grant < 0) begin
                    res.push_back('{tx_tsid_pkg::ST_NOFREE, 4'd0, 64'd0, 1'b1});
                end else begin
                    id_busy[grant]  = 1'b1;
                    id_start[grant] = w.now;
                    res.push_back('{tx_tsid_pkg::ST_GRANTED, 4'(grant), 64'd0, 1'b1});
                end
            end
            tx_tsid_pkg::FUNC_REPORT: begin
                if (id_busy[w.req_id]) begin
                    id_busy[w.req_id] = 1'b0;
                    res.push_back('{tx_tsid_pkg::ST_MATCHED, w.req_id, w.hw_ts, 1'b1});
                end else begin
                    res.push_back('{tx_tsid_pkg::ST_UNKNOWN, w.req_id, 64'd0, 1'b1});
                end
            end
            tx_tsid_pkg::FUNC_SWEEP: begin
                // Expired once now - start - expiry is non-negative, wrapping.
                for (int i = 0; i < NUM_IDS; i++) begin
                    overdue = w.now - id_start[i] - {1'b0, expiry_age};
                    if (id_busy[i] && freed < tx_tsid_pkg::MAX_SWEEP &&
                        !overdue[TIME_WIDTH-1]) begin
                        id_busy[i] = 1'b0;
                        res.push_back('{tx_tsid_pkg::ST_EXPIRED, 4'(i), 64'd0, 1'b0});
                        freed++;
                    end
                end
                if (res.size() > 0) res[res.size() - 1].last = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // Offer one word, with random gaps ahead of it, and book its results
    // once the block takes it. Entered and left at a falling edge.
    task automatic send_word(input t_stim_row row);
        t_outcome res[$];
        while (!steady && $urandom_range(99) < 24) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.func         <= row.w.func;
        item_if.req_id       <= row.w.req_id;
        item_if.hw_timestamp <= row.w.hw_ts;
        item_if.now_ticks    <= row.w.now;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        track_word(row.w, res);
        if (row.typed) begin
            awaited.push_back(row.want);
        end else begin
            foreach (res[k]) awaited.push_back(res[k]);
        end
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every booked result word has arrived.
    task automatic drain();
        item_if.valid <= 1'b0;
        do @(negedge i_clk); while (awaited.size() != 0);
    endtask

    // APB write of expiry_ticks, then a read back. psel stays high across
    // the two transfers so that it is never dropped and raised in one step.
    task automatic program_expiry(input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {tx_tsid_pkg::REG_EXPIRY, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        expiry_age = value[tx_tsid_pkg::EXPIRY_W-1:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {1'b0, expiry_age}) begin
            $error("expiry_ticks: expected %0h, got %0h", {1'b0, expiry_age}, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input logic [1:0] func, input logic [3:0] req_id,
                           input logic [63:0] hw_ts, input logic [31:0] now,
                           input bit typed, input logic [2:0] status,
                           input logic [3:0] slot_id, input logic [63:0] ts);
        t_stim_row row;
        row.w     = '{func, req_id, hw_ts, now};
        row.typed = typed;
        row.want  = '{status, slot_id, ts, 1'b1};
        dir_rows.push_back(row);
    endtask

    // Random word: mostly allocates and reports aimed at outstanding IDs,
    // some sweeps, a little noise. Time creeps forward with rare jumps.
    function automatic t_word random_word();
        t_word w;
        int    pick;
        int    busy_ids[$];
        pick = $urandom_range(99);
        if ($urandom_range(99) < 3) tick = $urandom;
        else                        tick += $urandom_range(300);
        w.now    = tick;
        w.hw_ts  = {$urandom, $urandom};
        w.req_id = 4'($urandom);
        if (pick < 45) begin
            w.func = tx_tsid_pkg::FUNC_ALLOC;
        end else if (pick < 80) begin
            w.func = tx_tsid_pkg::FUNC_REPORT;
            for (int i = 0; i < NUM_IDS; i++) begin
                if (id_busy[i]) busy_ids.push_back(i);
            end
            if (busy_ids.size() > 0 && $urandom_range(3) != 0) begin
                w.req_id = 4'(busy_ids[$urandom_range(busy_ids.size() - 1)]);
            end
        end else if (pick < 95) begin
            w.func = tx_tsid_pkg::FUNC_SWEEP;
        end else begin
            w.func = FUNC_UNUSED;
        end
        return w;
    endfunction

    // Receiver: stall at random, except through the steady stretch.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= 24);
        end
    end

    // Check each result word against the oldest booked one, field by field.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited.size() == 0) begin
                $error("unexpected result word: status %0d slot_id %0d",
                       res_if.status, res_if.slot_id);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    errors++;
                end
                if (res_if.slot_id !== want.slot_id) begin
                    $error("slot_id: expected %0d, got %0d", want.slot_id, res_if.slot_id);
                    errors++;
                end
                if (res_if.out_timestamp !== want.ts) begin
                    $error("out_timestamp: expected %0h, got %0h", want.ts,
                           res_if.out_timestamp);
                    errors++;
                end
                if (res_if.last_result !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last,
                           res_if.last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_if.valid        = 1'b0;
        item_if.func         = tx_tsid_pkg::FUNC_ALLOC;
        item_if.req_id       = '0;
        item_if.hw_timestamp = '0;
        item_if.now_ticks    = '0;
        id_busy              = '0;
        expiry_age           = tx_tsid_pkg::EXPIRY_RESET;
        foreach (id_start[i]) id_start[i] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, under the reset expiry of 5000 ticks.
        // Report against an empty pool, empty sweep, unused code.
        add_row(tx_tsid_pkg::FUNC_REPORT, 4'd0, '1, 32'd0, 1,
                tx_tsid_pkg::ST_UNKNOWN, 4'd0, 64'd0);
        add_row(tx_tsid_pkg::FUNC_SWEEP, 4'd0, 64'd0, 32'd0, 0,
                tx_tsid_pkg::ST_EXPIRED, 4'd0, 64'd0);
        add_row(FUNC_UNUSED, 4'd15, '1, '1, 0, tx_tsid_pkg::ST_UNKNOWN, 4'd0, 64'd0);
        // Grants at both ends of time, match with an all-ones stamp.
        add_row(tx_tsid_pkg::FUNC_ALLOC, 4'd0, 64'd0, 32'd0, 1,
                tx_tsid_pkg::ST_GRANTED, 4'd0, 64'd0);
        add_row(tx_tsid_pkg::FUNC_ALLOC, 4'd0, 64'd0, '1, 1,
                tx_tsid_pkg::ST_GRANTED, 4'd1, 64'd0);
        add_row(tx_tsid_pkg::FUNC_REPORT, 4'd1, '1, 32'd5, 1,
                tx_tsid_pkg::ST_MATCHED, 4'd1, '1);
        // Idle IDs, one never granted and one just released.
        add_row(tx_tsid_pkg::FUNC_REPORT, 4'd15, 64'h1234, 32'd6, 1,
                tx_tsid_pkg::ST_UNKNOWN, 4'd15, 64'd0);
        add_row(tx_tsid_pkg::FUNC_REPORT, 4'd1, 64'h5678, 32'd7, 1,
                tx_tsid_pkg::ST_UNKNOWN, 4'd1, 64'd0);
        // Fill the pool from the lowest free ID upwards, then overflow it.
        for (int k = 1; k < NUM_IDS; k++) begin
            add_row(tx_tsid_pkg::FUNC_ALLOC, 4'd0, 64'd0, 32'(10 * k), 1,
                    tx_tsid_pkg::ST_GRANTED, 4'(k), 64'd0);
        end
        add_row(tx_tsid_pkg::FUNC_ALLOC, 4'd0, 64'd0, 32'd200, 1,
                tx_tsid_pkg::ST_NOFREE, 4'd0, 64'd0);
        // Too early to expire anything; then late enough for the whole pool.
        add_row(tx_tsid_pkg::FUNC_SWEEP, 4'd0, 64'd0, 32'd1000, 0,
                tx_tsid_pkg::ST_EXPIRED, 4'd0, 64'd0);
        add_row(tx_tsid_pkg::FUNC_SWEEP, 4'd0, 64'd0, 32'h0000_2000, 0,
                tx_tsid_pkg::ST_EXPIRED, 4'd0, 64'd0);

        foreach (dir_rows[i]) send_word(dir_rows[i]);

        // Random phases, one per expiry setting; start near the wrap point.
        tick = 32'hFFFF_FF00;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            program_expiry(expiry_plan[p]);
            steady = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the sender mid-phase until the block has caught up.
                if (n == ITEMS_PER_PHASE / 2) drain();
                row.w     = random_word();
                row.typed = 1'b0;
                row.want  = '0;
                send_word(row);
            end
        end
        drain();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
